@@ hw/rtl/srisc_pkg.sv @@
// Shared constants, opcodes and types of the small RISC instruction step block.
`default_nettype none
package srisc_pkg;

   localparam int MEM_BYTES_DEF = 65536;
   localparam int NUM_REGS_DEF  = 32;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 32;
   localparam int WORD_W     = 32;
   localparam int PC_W       = 16;
   localparam int RIDX_W     = 5;

   localparam logic [RIDX_W-1:0] LINK_REG = 5'd31;

   localparam logic CMD_EXEC    = 1'b0;
   localparam logic CMD_PRELOAD = 1'b1;

   localparam logic [5:0] OP_HALT = 6'd0;
   localparam logic [5:0] OP_ADD  = 6'd1;
   localparam logic [5:0] OP_ADDI = 6'd2;
   localparam logic [5:0] OP_SUB  = 6'd3;
   localparam logic [5:0] OP_SUBI = 6'd4;
   localparam logic [5:0] OP_MUL  = 6'd5;
   localparam logic [5:0] OP_MULI = 6'd6;
   localparam logic [5:0] OP_LDB  = 6'd7;
   localparam logic [5:0] OP_STB  = 6'd8;
   localparam logic [5:0] OP_BEQ  = 6'd9;
   localparam logic [5:0] OP_BNE  = 6'd10;
   localparam logic [5:0] OP_BLT  = 6'd11;
   localparam logic [5:0] OP_BGT  = 6'd12;
   localparam logic [5:0] OP_BLE  = 6'd13;
   localparam logic [5:0] OP_BGE  = 6'd14;
   localparam logic [5:0] OP_JMP  = 6'd15;
   localparam logic [5:0] OP_JR   = 6'd16;
   localparam logic [5:0] OP_JAL  = 6'd17;
   localparam logic [5:0] OP_OUT  = 6'd18;

   // result word, next_pc in the low bits
   typedef struct packed {
      logic            bad_opcode;
      logic [7:0]      out_byte;
      logic            out_valid;
      logic            halted;
      logic [PC_W-1:0] next_pc;
   } rsp_type;

   // everything one executed word asks of the state
   typedef struct packed {
      logic [PC_W-1:0]   next_pc;
      logic              halt;
      logic              rf_we;
      logic [RIDX_W-1:0] rf_waddr;
      logic [WORD_W-1:0] rf_wdata;
      logic              mem_we;
      logic              mem_re;
      logic [PC_W-1:0]   mem_addr;
      logic [7:0]        mem_wdata;
      logic              out_valid;
      logic [7:0]        out_byte;
      logic              bad_opcode;
   } exec_type;

endpackage
`default_nettype wire

@@ hw/rtl/srisc_exec.sv @@
// Instruction decode and execute: next pc, register and memory requests, out byte.
`default_nettype none
module srisc_exec (
   input  logic                            cmd,
   input  logic [srisc_pkg::WORD_W-1:0]    inst,
   input  logic [srisc_pkg::PC_W-1:0]      load_address,
   input  logic [7:0]                      load_byte,
   input  logic [srisc_pkg::WORD_W-1:0]    a_val,
   input  logic [srisc_pkg::WORD_W-1:0]    b_val,
   input  logic [srisc_pkg::WORD_W-1:0]    c_val,
   input  logic [srisc_pkg::PC_W-1:0]      pc,
   input  logic                            halt,
   output srisc_pkg::exec_type             ex
);
   import srisc_pkg::*;

   logic [5:0]        opc;
   logic [WORD_W-1:0] sext;
   logic [PC_W-1:0]   pc_inc;
   logic [PC_W-1:0]   br_target;
   logic [PC_W-1:0]   eff_addr;
   logic              take;

   always_comb begin
      opc       = inst[31:26];
      sext      = {{16{inst[15]}}, inst[15:0]};
      pc_inc    = pc + 16'd4;
      // pc + 4*imm, wrapped to 16 bits
      br_target = pc + {inst[13:0], 2'b00};
      eff_addr  = b_val[PC_W-1:0] + inst[15:0];
      take      = 1'b0;

      ex           = '0;
      ex.next_pc   = pc;
      ex.halt      = halt;
      ex.rf_waddr  = inst[25:21];
      ex.mem_addr  = eff_addr;
      ex.mem_wdata = a_val[7:0];

      if (cmd == CMD_PRELOAD) begin
         ex.mem_we    = 1'b1;
         ex.mem_addr  = load_address;
         ex.mem_wdata = load_byte;
      end else if (!halt) begin
         ex.next_pc = pc_inc;
         case (opc)
            OP_HALT: ex.halt = 1'b1;
            OP_ADD: begin
               ex.rf_we    = 1'b1;
               ex.rf_wdata = b_val + c_val;
            end
            OP_ADDI: begin
               ex.rf_we    = 1'b1;
               ex.rf_wdata = b_val + sext;
            end
            OP_SUB: begin
               ex.rf_we    = 1'b1;
               ex.rf_wdata = b_val - c_val;
            end
            OP_SUBI: begin
               ex.rf_we    = 1'b1;
               ex.rf_wdata = b_val - sext;
            end
            OP_MUL: begin
               ex.rf_we    = 1'b1;
               ex.rf_wdata = b_val * c_val;
            end
            OP_MULI: begin
               ex.rf_we    = 1'b1;
               ex.rf_wdata = b_val * sext;
            end
            OP_LDB: ex.mem_re = 1'b1;
            OP_STB: ex.mem_we = 1'b1;
            OP_BEQ, OP_BNE, OP_BLT, OP_BGT, OP_BLE, OP_BGE: begin
               case (opc)
                  OP_BEQ:  take = (a_val == b_val);
                  OP_BNE:  take = (a_val != b_val);
                  OP_BLT:  take = ($signed(a_val) < $signed(b_val));
                  OP_BGT:  take = ($signed(b_val) < $signed(a_val));
                  OP_BLE:  take = !($signed(b_val) < $signed(a_val));
                  default: take = !($signed(a_val) < $signed(b_val));
               endcase
               if (take) begin
                  ex.next_pc = br_target;
               end
            end
            OP_JMP: ex.next_pc = inst[15:0];
            OP_JR:  ex.next_pc = a_val[PC_W-1:0];
            OP_JAL: begin
               ex.rf_we    = 1'b1;
               ex.rf_waddr = LINK_REG;
               ex.rf_wdata = {16'd0, pc_inc};
               ex.next_pc  = inst[15:0];
            end
            OP_OUT: begin
               ex.out_valid = 1'b1;
               ex.out_byte  = a_val[7:0];
            end
            default: ex.bad_opcode = 1'b1;
         endcase
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/srisc_regfile.sv @@
// Register file: two synchronous RAM copies, reset valid bits, same-edge write forwarding.
`default_nettype none
module srisc_regfile #(
   parameter  int NUM_REGS = srisc_pkg::NUM_REGS_DEF,
   localparam int AW       = $clog2(NUM_REGS)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [AW-1:0]                ra_addr,
   input  logic [AW-1:0]                rb_addr,
   input  logic [AW-1:0]                rc_addr,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [srisc_pkg::WORD_W-1:0] wr_data,
   output logic [srisc_pkg::WORD_W-1:0] ra_data,
   output logic [srisc_pkg::WORD_W-1:0] rb_data,
   output logic [srisc_pkg::WORD_W-1:0] rc_data
);
   import srisc_pkg::*;

   // copy 0 serves ports a and b, copy 1 serves port c
   logic [WORD_W-1:0] bank0 [NUM_REGS];
   logic [WORD_W-1:0] bank1 [NUM_REGS];

   logic [NUM_REGS-1:0] valid_ff;
   logic [WORD_W-1:0]   ra_q_ff, rb_q_ff, rc_q_ff;
   logic [AW-1:0]       ra_addr_ff, rb_addr_ff, rc_addr_ff;
   logic                ra_v_ff, rb_v_ff, rc_v_ff;
   logic                fwd_en_ff;
   logic [AW-1:0]       fwd_addr_ff;
   logic [WORD_W-1:0]   fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bank0[wr_addr] <= wr_data;
         bank1[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         ra_q_ff     <= bank0[ra_addr];
         rb_q_ff     <= bank0[rb_addr];
         rc_q_ff     <= bank1[rc_addr];
         ra_addr_ff  <= ra_addr;
         rb_addr_ff  <= rb_addr;
         rc_addr_ff  <= rc_addr;
         fwd_addr_ff <= wr_addr;
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         ra_v_ff   <= 1'b0;
         rb_v_ff   <= 1'b0;
         rc_v_ff   <= 1'b0;
         fwd_en_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            ra_v_ff   <= valid_ff[ra_addr];
            rb_v_ff   <= valid_ff[rb_addr];
            rc_v_ff   <= valid_ff[rc_addr];
            // RAM returns old data on a write at the read edge
            fwd_en_ff <= wr_en;
         end
      end
   end

   always_comb begin
      if (fwd_en_ff && (fwd_addr_ff == ra_addr_ff)) ra_data = fwd_data_ff;
      else if (ra_v_ff)                             ra_data = ra_q_ff;
      else                                          ra_data = '0;

      if (fwd_en_ff && (fwd_addr_ff == rb_addr_ff)) rb_data = fwd_data_ff;
      else if (rb_v_ff)                             rb_data = rb_q_ff;
      else                                          rb_data = '0;

      if (fwd_en_ff && (fwd_addr_ff == rc_addr_ff)) rc_data = fwd_data_ff;
      else if (rc_v_ff)                             rc_data = rc_q_ff;
      else                                          rc_data = '0;
   end

endmodule
`default_nettype wire

@@ hw/rtl/srisc_bytemem.sv @@
// Byte memory: one write and one registered read port, zero sweep after reset.
`default_nettype none
module srisc_bytemem #(
   parameter  int MEM_BYTES = srisc_pkg::MEM_BYTES_DEF,  // power of two
   localparam int AW        = $clog2(MEM_BYTES)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data,
   output logic          busy
);
   logic [7:0]    mem [MEM_BYTES];
   logic [AW-1:0] clr_cnt_ff;
   logic          busy_ff;
   logic [7:0]    rd_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_cnt_ff <= '0;
      end else if (busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == AW'(MEM_BYTES - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_cnt_ff] <= 8'd0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_q_ff;
   assign busy    = busy_ff;

endmodule
`default_nettype wire

@@ hw/rtl/simple_risc_instruction_step.sv @@
// Top level: executes instruction words and preloads bytes for a small 32-register machine.
//
// Usage:
//  - req channel: one word per instruction (req_tuser = 0) or per memory preload byte
//    (req_tuser = 1). Words are taken on req_tvalid && req_tready.
//  - rsp channel: exactly one result word per request word, in order: next pc, halt
//    flag, emitted out byte with its valid bit, and the undefined-opcode flag.
//  - Path: a result is registered in the execute stage and then in the output queue;
//    a byte load also passes the byte-load completion stage.
//  - Throughput: one word per cycle while the output queue has room; a byte load holds
//    the pipe because its register write waits on the byte RAM's registered read.
//  - Register operands are read from the register RAM on the accepting edge and the
//    write of the word ahead, landing on that same edge, is forwarded.
//  - Reset: pc, halt flag and registers read zero at once; the byte RAM is swept to
//    zero address by address, during which req_tready stays low.
//  - Receiver stall: results wait in a two-entry output queue; with it full the
//    execute stage holds and req_tready drops. req_tready never looks at rsp_tready.
//  - Once halted, instruction words only report the current pc; preloads still work.
`default_nettype none
module simple_risc_instruction_step #(
   parameter int MEM_BYTES = srisc_pkg::MEM_BYTES_DEF,
   parameter int NUM_REGS  = srisc_pkg::NUM_REGS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request: instruction[31:0], load_address[47:32], load_byte[55:48]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [srisc_pkg::REQ_DATA_W-1:0] req_tdata,
   // request user: command[0] (0 execute, 1 preload)
   input  logic [0:0]                       req_tuser,
   // result: next_pc[15:0], halted[16], out_valid[17], out_byte[25:18],
   //         bad_opcode[26], zero[31:27]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [srisc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import srisc_pkg::*;

   localparam int MEM_AW = $clog2(MEM_BYTES);
   localparam int REG_AW = $clog2(NUM_REGS);

   // execute stage
   logic              e_valid_ff, e_valid_in;
   logic              e_cmd_ff;
   logic [WORD_W-1:0] e_inst_ff;
   logic [PC_W-1:0]   e_laddr_ff;
   logic [7:0]        e_lbyte_ff;
   logic              e_fire;

   // byte-load completion stage
   logic              m_valid_ff, m_valid_in;
   logic [RIDX_W-1:0] m_dest_ff;
   rsp_type           m_rsp_ff;
   logic              m_fire;

   // architectural pc and halt
   logic [PC_W-1:0]   pc_ff;
   logic              halt_ff;

   // output queue
   rsp_type           fifo_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push, pop;
   rsp_type           push_data;
   rsp_type           e_rsp;

   logic              accept;
   logic              q_room;
   logic              mem_busy;
   logic [7:0]        mem_rd_data;
   logic [WORD_W-1:0] a_val, b_val, c_val;
   exec_type          ex;

   logic              rf_we;
   logic [REG_AW-1:0] rf_waddr;
   logic [WORD_W-1:0] rf_wdata;

   srisc_regfile #(.NUM_REGS(NUM_REGS)) u_regfile (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .ra_addr (req_tdata[21 +: REG_AW]),
      .rb_addr (req_tdata[16 +: REG_AW]),
      .rc_addr (req_tdata[11 +: REG_AW]),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .ra_data (a_val),
      .rb_data (b_val),
      .rc_data (c_val)
   );

   srisc_exec u_exec (
      .cmd          (e_cmd_ff),
      .inst         (e_inst_ff),
      .load_address (e_laddr_ff),
      .load_byte    (e_lbyte_ff),
      .a_val        (a_val),
      .b_val        (b_val),
      .c_val        (c_val),
      .pc           (pc_ff),
      .halt         (halt_ff),
      .ex           (ex)
   );

   srisc_bytemem #(.MEM_BYTES(MEM_BYTES)) u_bytemem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (e_fire && ex.mem_we),
      .wr_addr (ex.mem_addr[MEM_AW-1:0]),
      .wr_data (ex.mem_wdata),
      .rd_en   (e_fire && ex.mem_re),
      .rd_addr (ex.mem_addr[MEM_AW-1:0]),
      .rd_data (mem_rd_data),
      .busy    (mem_busy)
   );

   // queue space is judged on the registered count only, so no ready path
   // runs from rsp to req
   assign q_room = (cnt_ff != 2'd2);
   assign e_fire = e_valid_ff && q_room;
   assign m_fire = m_valid_ff && q_room;

   // a byte load holds off the next word; while it completes, execute is empty
   assign req_tready = !mem_busy && (!m_valid_ff || m_fire) &&
                       (!e_valid_ff || (e_fire && !ex.mem_re));
   assign accept     = req_tvalid && req_tready;

   // only one of execute and load completion ever writes in a cycle
   assign rf_we    = m_fire || (e_fire && ex.rf_we);
   assign rf_waddr = m_valid_ff ? m_dest_ff[REG_AW-1:0] : ex.rf_waddr[REG_AW-1:0];
   assign rf_wdata = m_valid_ff ? {24'd0, mem_rd_data} : ex.rf_wdata;

   always_comb begin
      e_rsp            = '0;
      e_rsp.next_pc    = ex.next_pc;
      e_rsp.halted     = ex.halt;
      e_rsp.out_valid  = ex.out_valid;
      e_rsp.out_byte   = ex.out_byte;
      e_rsp.bad_opcode = ex.bad_opcode;
   end

   assign push      = m_fire || (e_fire && !ex.mem_re);
   assign push_data = m_fire ? m_rsp_ff : e_rsp;
   assign pop       = rsp_tvalid && rsp_tready;

   assign e_valid_in = accept ? 1'b1 : (e_fire ? 1'b0 : e_valid_ff);
   assign m_valid_in = (e_fire && ex.mem_re) ? 1'b1 : (m_fire ? 1'b0 : m_valid_ff);

   always_comb begin
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
         pc_ff      <= '0;
         halt_ff    <= 1'b0;
         wr_ptr_ff  <= 1'b0;
         rd_ptr_ff  <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         e_valid_ff <= e_valid_in;
         m_valid_ff <= m_valid_in;
         cnt_ff     <= cnt_in;
         if (e_fire) begin
            pc_ff   <= ex.next_pc;
            halt_ff <= ex.halt;
         end
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         e_cmd_ff   <= req_tuser[0];
         e_inst_ff  <= req_tdata[31:0];
         e_laddr_ff <= req_tdata[47:32];
         e_lbyte_ff <= req_tdata[55:48];
      end
      // a load result carries pc and halt only; out and bad flags are zero
      if (e_fire && ex.mem_re) begin
         m_dest_ff <= ex.rf_waddr;
         m_rsp_ff  <= e_rsp;
      end
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = RSP_DATA_W'(fifo_ff[rd_ptr_ff]);

endmodule
`default_nettype wire

@@ hw/rtl/srisc_checker.sv @@
// Port-level checker of the instruction step block, bound to its top level.
`default_nettype none
module srisc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);
   logic seen_halt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_halt_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready && rsp_tdata[16]) begin
         seen_halt_ff <= 1'b1;
      end
   end

   // memory sweep keeps the request side closed right after reset
   a_sweep_after_reset: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("request taken during memory sweep");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // halt is sticky until reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && seen_halt_ff |-> rsp_tdata[16])
      else $error("halt flag dropped");

   a_rsp_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[17] && rsp_tdata[26]) && (rsp_tdata[31:27] == 5'd0) &&
                     (rsp_tdata[17] || (rsp_tdata[25:18] == 8'd0)))
      else $error("inconsistent result fields");

endmodule

bind simple_risc_instruction_step srisc_checker u_srisc_checker (.*);
`default_nettype wire
